// File: src/tchs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tchs_pkg;

    // Fixed geometry of the cipher state and the counter planes
    localparam int BLOCK_BITS = 16;
    localparam int FIX_BITS   = 4;
    localparam int OUT_BITS   = 4;
    localparam int NBINS      = BLOCK_BITS - FIX_BITS + 1;
    localparam int NFIX       = 1 << FIX_BITS;
    localparam int NOUT       = 1 << OUT_BITS;

    localparam int DEF_ROUNDS      = 31;
    localparam int DEF_COUNT_WIDTH = 16;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int RND_W   = 5;
    localparam int SI_W    = 12;
    localparam int K_W     = 4;
    localparam int T_W     = 24;
    localparam int POS_W   = $clog2(BLOCK_BITS);
    localparam int BIN_W   = $clog2(NBINS);
    localparam int LEN_W   = $clog2(SI_W + 1);

    // Commands
    localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // Configuration registers
    localparam int NREG   = 4;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_OUT_POS_0 = 2'd0;
    localparam logic [1:0] REG_OUT_POS_1 = 2'd1;
    localparam logic [1:0] REG_OUT_POS_2 = 2'd2;
    localparam logic [1:0] REG_OUT_POS_3 = 2'd3;

    // Statistic arithmetic: any deviation at or above 2^SQ_IN_W saturates the result
    localparam int SQ_IN_W  = 17;
    localparam int SQ_W     = 2 * SQ_IN_W;
    localparam int ACC_W    = SQ_W + OUT_BITS;
    localparam int RD_SHIFT = 4;
    localparam int SH_W     = ACC_W + RD_SHIFT;
    localparam logic [T_W-1:0] T_MAX = '1;

    localparam int STEP_W   = $clog2(NOUT + 2);
    localparam int SUM_LAST = NOUT + 1;

    typedef logic [NREG-1:0][POS_W-1:0] pos_vec_t;

    typedef struct packed {
        logic                load;
        logic                mem_rd;
        logic                mem_wr;
        logic                clr_start;
        logic                clr_step;
        logic                bin_step;
        logic                acc_clr;
        logic                d_en;
        logic                sq_en;
        logic                acc_en;
        logic                res_load;
        logic                res_zero;
        logic [OUT_BITS-1:0] lane;
    } ctrl_cmd_t;

    typedef struct packed {
        logic obs_ok;
        logic rd_ok;
        logic bin_last;
        logic clr_last;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// File: src/tchs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module tchs_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tchs_pkg::APB_AW-1:0]   paddr,
    input  logic [tchs_pkg::APB_DW-1:0]   pwdata,
    output logic [tchs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output tchs_pkg::pos_vec_t            out_pos
);
    import tchs_pkg::*;

    pos_vec_t   pos_reg;
    pos_vec_t   pos_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        pos_next = pos_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_OUT_POS_0: pos_next[0] = pwdata[POS_W-1:0];
                REG_OUT_POS_1: pos_next[1] = pwdata[POS_W-1:0];
                REG_OUT_POS_2: pos_next[2] = pwdata[POS_W-1:0];
                REG_OUT_POS_3: pos_next[3] = pwdata[POS_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_OUT_POS_0: prdata = APB_DW'(pos_reg[0]);
            REG_OUT_POS_1: prdata = APB_DW'(pos_reg[1]);
            REG_OUT_POS_2: prdata = APB_DW'(pos_reg[2]);
            REG_OUT_POS_3: prdata = APB_DW'(pos_reg[3]);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0] <= POS_W'(0);
            pos_reg[1] <= POS_W'(1);
            pos_reg[2] <= POS_W'(2);
            pos_reg[3] <= POS_W'(3);
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign out_pos = pos_reg;

endmodule

`default_nettype wire

// File: src/tchs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tchs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tchs_pkg::CMD_W-1:0]   cmd,
    input  tchs_pkg::ctrl_sts_t          sts,
    output tchs_pkg::ctrl_cmd_t          ctl,
    output logic                         busy,
    output logic                         done
);
    import tchs_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_OBS_RD = 3'd2;
    localparam logic [2:0] S_OBS_WR = 3'd3;
    localparam logic [2:0] S_RD_RD  = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              done_reg;
    logic              done_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        ctl        = '0;
        ctl.lane   = step_reg[OUT_BITS-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.mem_wr   = 1'b1;
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    unique case (cmd)
                        CMD_OBSERVE:
                        begin
                            if (sts.obs_ok)
                            begin
                                state_next = S_OBS_RD;
                            end
                        end
                        CMD_READ:
                        begin
                            if (sts.rd_ok)
                            begin
                                state_next = S_RD_RD;
                            end
                            else
                            begin
                                ctl.res_load = 1'b1;
                                ctl.res_zero = 1'b1;
                                done_next    = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctl.clr_start = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_OBS_RD:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_OBS_WR;
            end
            S_OBS_WR:
            begin
                ctl.mem_wr   = 1'b1;
                ctl.bin_step = 1'b1;
                state_next   = sts.bin_last ? S_IDLE : S_OBS_RD;
            end
            S_RD_RD:
            begin
                ctl.mem_rd  = 1'b1;
                ctl.acc_clr = 1'b1;
                step_next   = '0;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                // lane select, square and accumulate run as a pipeline over the lane steps
                ctl.d_en   = step_reg < STEP_W'(NOUT);
                ctl.sq_en  = (step_reg >= STEP_W'(1)) && (step_reg <= STEP_W'(NOUT));
                ctl.acc_en = step_reg >= STEP_W'(2);
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_LAST))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ctl.res_load = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

`ifndef SYNTH
    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && !sts.clr_last |=> state_reg == S_CLEAR)
        else $error("clearing pass left early");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN) || $past(state_reg == S_IDLE && start))
        else $error("result strobe without a read");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |-> step_reg <= STEP_W'(SUM_LAST))
        else $error("sum step counter overran");
`endif

endmodule

`default_nettype wire

// File: src/tchs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tchs_datapath #(
    parameter int ROUNDS      = tchs_pkg::DEF_ROUNDS,
    parameter int COUNT_WIDTH = tchs_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tchs_pkg::ctrl_cmd_t              ctl,
    output tchs_pkg::ctrl_sts_t              sts,
    input  logic [tchs_pkg::CMD_W-1:0]       cmd,
    input  logic [tchs_pkg::RND_W-1:0]       round,
    input  logic [tchs_pkg::FIX_BITS-1:0]    fixation,
    input  logic [tchs_pkg::BLOCK_BITS-1:0]  state_word,
    input  logic [tchs_pkg::SI_W-1:0]        sample_index,
    input  logic [tchs_pkg::K_W-1:0]         size_exp,
    input  tchs_pkg::pos_vec_t               out_pos,
    output logic [tchs_pkg::T_W-1:0]         t_value
);
    import tchs_pkg::*;

    localparam int ROWB   = (ROUNDS + 1) * NBINS;
    localparam int ROWB_W = $clog2(ROWB);
    localparam int ROWS   = ROWB * NFIX;
    localparam int ADDR_W = ROWB_W + FIX_BITS;
    localparam int ROW_W  = NOUT * COUNT_WIDTH;
    localparam int DW     = (COUNT_WIDTH + 5 > SQ_IN_W + 1) ? COUNT_WIDTH + 5 : SQ_IN_W + 1;
    localparam int RCMP_W = RND_W + 2;

    logic [ROW_W-1:0]       mem [ROWS];

    logic [RND_W-1:0]       round_reg;
    logic [FIX_BITS-1:0]    fix_reg;
    logic [OUT_BITS-1:0]    eta_reg;
    logic [BIN_W-1:0]       bin_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [ROW_W-1:0]       rd_data_reg;
    logic [SQ_IN_W-1:0]     d_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic                   sat_reg;
    logic [T_W-1:0]         t_value_reg;

    logic [LEN_W-1:0]       len;
    logic [OUT_BITS-1:0]    eta;
    logic                   round_ok;
    logic [ROWB_W-1:0]      rb;
    logic [ADDR_W-1:0]      mem_addr;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] inc_cnt;
    logic [ROW_W-1:0]       wr_row;
    logic [COUNT_WIDTH-1:0] lane_cnt;
    logic [DW-1:0]          scaled;
    logic [DW-1:0]          expect_v;
    logic [DW-1:0]          diff;
    logic                   d_big;
    logic [SH_W-1:0]        ext;
    logic [SH_W-1:0]        shifted;
    logic [T_W-1:0]         t_next;

    // bit length of the sample index
    always_comb
    begin
        len = '0;
        for (int i = 0; i < SI_W; i++)
        begin
            if (sample_index[i])
            begin
                len = LEN_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < OUT_BITS; j++)
        begin
            eta[j] = state_word[out_pos[j]];
        end
    end

    assign round_ok     = RCMP_W'(round) <= RCMP_W'(ROUNDS);
    assign sts.obs_ok   = round_ok && (len < LEN_W'(NBINS));
    assign sts.rd_ok    = round_ok && (size_exp < K_W'(NBINS));
    assign sts.bin_last = bin_reg == BIN_W'(NBINS - 1);
    assign sts.clr_last = clr_addr_reg == ADDR_W'(ROWS - 1);

    assign rb       = ROWB_W'(round_reg) * ROWB_W'(NBINS) + ROWB_W'(bin_reg);
    assign mem_addr = ctl.clr_step ? clr_addr_reg : {rb, fix_reg};

    // saturating increment of the observed output's counter
    assign cur_cnt = rd_data_reg[eta_reg*COUNT_WIDTH +: COUNT_WIDTH];
    assign inc_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

    always_comb
    begin
        wr_row = rd_data_reg;
        wr_row[eta_reg*COUNT_WIDTH +: COUNT_WIDTH] = inc_cnt;
        if (ctl.clr_step)
        begin
            wr_row = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_wr)
        begin
            mem[mem_addr] <= wr_row;
        end
        if (ctl.mem_rd)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // deviation of one lane: |16c - 2^k|
    assign lane_cnt = rd_data_reg[ctl.lane*COUNT_WIDTH +: COUNT_WIDTH];
    assign scaled   = DW'(lane_cnt) << 4;
    assign expect_v = DW'(1) << bin_reg;
    assign diff     = (scaled >= expect_v) ? scaled - expect_v : expect_v - scaled;
    assign d_big    = |diff[DW-1:SQ_IN_W];

    // scale by 256 / 2^(k+4) and clamp
    assign ext = SH_W'(acc_reg);
    always_comb
    begin
        if (bin_reg < BIN_W'(RD_SHIFT))
        begin
            shifted = ext << (BIN_W'(RD_SHIFT) - bin_reg);
        end
        else
        begin
            shifted = ext >> (bin_reg - BIN_W'(RD_SHIFT));
        end
        if (ctl.res_zero)
        begin
            t_next = '0;
        end
        else if (sat_reg || (shifted > SH_W'(T_MAX)))
        begin
            t_next = T_MAX;
        end
        else
        begin
            t_next = shifted[T_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            round_reg <= round;
            fix_reg   <= fixation;
            eta_reg   <= eta;
            bin_reg   <= (cmd == CMD_READ) ? BIN_W'(size_exp) : BIN_W'(len);
        end
        else if (ctl.bin_step)
        begin
            bin_reg <= bin_reg + BIN_W'(1);
        end
        if (ctl.acc_clr)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (ctl.d_en)
            begin
                d_reg   <= diff[SQ_IN_W-1:0];
                sat_reg <= sat_reg | d_big;
            end
            if (ctl.acc_en)
            begin
                acc_reg <= acc_reg + ACC_W'(sq_reg);
            end
        end
        if (ctl.sq_en)
        begin
            sq_reg <= d_reg * d_reg;
        end
        if (ctl.res_load)
        begin
            t_value_reg <= t_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (ctl.clr_start)
        begin
            clr_addr_reg <= '0;
        end
        else if (ctl.clr_step)
        begin
            clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
        end
    end

    assign t_value = t_value_reg;

`ifndef SYNTH
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mem_wr && !ctl.clr_step |-> $past(ctl.mem_rd))
        else $error("counter row written without a fresh read");

    a_sat_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load && !ctl.res_zero && sat_reg |=> t_value == T_MAX)
        else $error("saturated statistic not clamped");

    a_clr_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clr_step && sts.clr_last |=> clr_addr_reg == '0)
        else $error("clear address did not wrap");
`endif

endmodule

`default_nettype wire

// File: src/trail_histogram_chi_square.sv
`timescale 1ns / 1ps
`default_nettype none

// Histogram engine for saturation experiments, with a chi-square read-out.
// Command channel: an item is taken at a clock edge with start high and busy
// low. cmd selects observe (count one state word), read (return the statistic
// of one round/bin/fixation plane) or clear (zero every counter).
// Observe walks the bins from the bit length of sample_index up to 12: each bin
// is a read-modify-write of one counter row in the single-port memory.
// Read holds busy through one row read, 16 lanes plus the drain steps
// through a deviation / 17x17 square / accumulate pipeline, then the final
// scaling. Its result appears on t_value with done high for exactly one
// cycle, the first cycle with busy low again; an out-of-range read returns 0
// in the cycle after it is taken. The receiver cannot stall: each result
// is shown once.
// Reset and clear both start a clearing pass of one memory row per cycle,
// covering all (ROUNDS+1)*13*16 rows (6656 by default), with busy high throughout.
// Configuration is an APB port with pready tied high; out_pos_0..3 sit at
// byte addresses 0, 4, 8, 12 and should be written only while idle.

module trail_histogram_chi_square #(
    parameter int ROUNDS      = tchs_pkg::DEF_ROUNDS,
    parameter int COUNT_WIDTH = tchs_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tchs_pkg::CMD_W-1:0]       cmd,
    input  logic [tchs_pkg::RND_W-1:0]       round,
    input  logic [tchs_pkg::FIX_BITS-1:0]    fixation,
    input  logic [tchs_pkg::BLOCK_BITS-1:0]  state_word,
    input  logic [tchs_pkg::SI_W-1:0]        sample_index,
    input  logic [tchs_pkg::K_W-1:0]         size_exp,
    output logic                             done,
    output logic [tchs_pkg::T_W-1:0]         t_value,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tchs_pkg::APB_AW-1:0]      paddr,
    input  logic [tchs_pkg::APB_DW-1:0]      pwdata,
    output logic [tchs_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import tchs_pkg::*;

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;
    pos_vec_t  out_pos;

    tchs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .out_pos (out_pos)
    );

    tchs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    tchs_datapath #(
        .ROUNDS      (ROUNDS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .round        (round),
        .fixation     (fixation),
        .state_word   (state_word),
        .sample_index (sample_index),
        .size_exp     (size_exp),
        .out_pos      (out_pos),
        .t_value      (t_value)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_trail_histogram_chi_square.sv
`timescale 1ns / 1ps

module tb_trail_histogram_chi_square;

    import tchs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int CELLS          = (DEF_ROUNDS + 1) * NBINS * NFIX * NOUT;
    localparam int DRAIN_CYCLES   = 7000;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SAT_OBS        = 80;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [RND_W-1:0]      round;
        logic [FIX_BITS-1:0]   fixation;
        logic [BLOCK_BITS-1:0] state_word;
        logic [SI_W-1:0]       sample_index;
        logic [K_W-1:0]        size_exp;
    } hist_cmd_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic [CMD_W-1:0]      cmd          = '0;
    logic [RND_W-1:0]      round        = '0;
    logic [FIX_BITS-1:0]   fixation     = '0;
    logic [BLOCK_BITS-1:0] state_word   = '0;
    logic [SI_W-1:0]       sample_index = '0;
    logic [K_W-1:0]        size_exp     = '0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_AW-1:0]     paddr        = '0;
    logic [APB_DW-1:0]     pwdata       = '0;
    logic                  busy;
    logic                  done;
    logic [T_W-1:0]        t_value;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    trail_histogram_chi_square uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .round        (round),
        .fixation     (fixation),
        .state_word   (state_word),
        .sample_index (sample_index),
        .size_exp     (size_exp),
        .done         (done),
        .t_value      (t_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 clk = ~clk;

    // Histogram state mirrored from the block's point of view
    bit   [DEF_COUNT_WIDTH-1:0] plane_count [CELLS];
    logic [POS_W-1:0]           pos_sel [NREG] = '{4'd0, 4'd1, 4'd2, 4'd3};
    logic [T_W-1:0]             t_expect_q [$];

    hist_cmd_t   pending_q [$];
    int          idle_pct       = 17;
    int          issued_count   = 0;
    int          accept_count   = 0;
    int          idle_cycles    = 0;
    int          mismatches     = 0;
    int          n_observe      = 0;
    int          n_read         = 0;
    int          n_clear        = 0;
    int          n_read_sat     = 0;
    int          n_settings     = 1;
    logic [RND_W-1:0]    hot_round [2];
    logic [FIX_BITS-1:0] hot_fix [2];

    function automatic int unsigned cell_index(int unsigned r, int unsigned b,
                                               int unsigned f, int unsigned e);
        return ((r * NBINS + b) * NFIX + f) * NOUT + e;
    endfunction

    function automatic logic [T_W-1:0] chi_square_x256(int unsigned r, int unsigned k,
                                                       int unsigned f);
        longint unsigned acc;
        longint unsigned flat;
        longint unsigned scaled;
        longint unsigned dev;
        acc  = 0;
        flat = 64'd1 << k;
        for (int e = 0; e < NOUT; e++) begin
            scaled = {44'd0, plane_count[cell_index(r, k, f, e)], 4'd0};
            dev    = (scaled >= flat) ? scaled - flat : flat - scaled;
            acc    = acc + dev * dev;
        end
        // divide by 2^(k+4), then scale by 256
        if (k >= 4)
            acc = acc >> (k - 4);
        else
            acc = acc << (4 - k);
        return (acc > T_MAX) ? T_MAX : acc[T_W-1:0];
    endfunction

    function automatic void apply_command(hist_cmd_t c);
        logic [OUT_BITS-1:0] eta;
        int unsigned         len;
        int unsigned         idx;
        logic [T_W-1:0]      tv;
        case (c.cmd)
            CMD_OBSERVE: begin
                n_observe++;
                for (int j = 0; j < OUT_BITS; j++)
                    eta[j] = c.state_word[pos_sel[j]];
                len = 0;
                for (int i = 0; i < SI_W; i++)
                    if (c.sample_index[i])
                        len = i + 1;
                for (int b = len; b < NBINS; b++) begin
                    idx = cell_index(c.round, b, c.fixation, eta);
                    if (plane_count[idx] != '1)
                        plane_count[idx]++;
                end
            end
            CMD_READ: begin
                n_read++;
                if (c.size_exp >= NBINS)
                    tv = '0;
                else
                    tv = chi_square_x256(c.round, c.size_exp, c.fixation);
                if (tv == T_MAX)
                    n_read_sat++;
                t_expect_q.push_back(tv);
            end
            CMD_CLEAR: begin
                n_clear++;
                foreach (plane_count[i])
                    plane_count[i] = '0;
            end
            default: ;
        endcase
    endfunction

    // Driver: one transaction per start/!busy handshake, random gaps between
    always @(negedge clk) begin : drive_proc
        hist_cmd_t  nxt;
        logic [63:0] noise;
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!(start && issued_count != accept_count)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_q.pop_front();
                {cmd, round, fixation, state_word, sample_index, size_exp} <= nxt;
                start <= 1'b1;
                issued_count++;
            end else begin
                // drop start and scramble the payload
                noise = {$urandom, $urandom};
                {cmd, round, fixation, state_word, sample_index, size_exp}
                    <= noise[$bits(hist_cmd_t)-1:0];
                start <= 1'b0;
            end
        end
    end

    // Monitor: check results, predict accepted transactions, track config writes
    always @(posedge clk) begin : watch_proc
        logic           progress;
        logic [T_W-1:0] want;
        progress = 1'b0;
        if (rst_n) begin
            if (done) begin
                progress = 1'b1;
                if (t_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: t_value %0d delivered with no read pending",
                                 $time, t_value);
                end else begin
                    want = t_expect_q.pop_front();
                    if (t_value !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: t_value mismatch: expected %0d, got %0d",
                                     $time, want, t_value);
                    end
                end
            end
            if (start && !busy) begin
                progress = 1'b1;
                accept_count++;
                apply_command({cmd, round, fixation, state_word, sample_index, size_exp});
            end
            if (psel && penable && pwrite && pready) begin
                progress = 1'b1;
                pos_sel[paddr[APB_AW-1:2]] = pwdata[POS_W-1:0];
            end
        end
        idle_cycles = progress ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void queue_cmd(logic [CMD_W-1:0] c, logic [RND_W-1:0] r,
                                      logic [FIX_BITS-1:0] f, logic [BLOCK_BITS-1:0] sw,
                                      logic [SI_W-1:0] si, logic [K_W-1:0] k);
        hist_cmd_t item;
        item.cmd          = c;
        item.round        = r;
        item.fixation     = f;
        item.state_word   = sw;
        item.sample_index = si;
        item.size_exp     = k;
        pending_q.push_back(item);
    endfunction

    // Mostly observes and reads on a few hot planes so counts build up
    function automatic void queue_mixed_traffic(int count);
        hist_cmd_t c;
        int        got;
        int        sel;
        int        len;
        int        rv;
        hot_round[0] = 5'($urandom);
        hot_round[1] = 5'($urandom);
        hot_fix[0]   = 4'($urandom);
        hot_fix[1]   = 4'($urandom);
        got = 0;
        while (got < count) begin
            sel = $urandom_range(99);
            if (sel < 64)
                c.cmd = CMD_OBSERVE;
            else if (sel < 93)
                c.cmd = CMD_READ;
            else if (sel < 97)
                c.cmd = CMD_UNUSED;
            else
                c.cmd = CMD_CLEAR;
            rv = $urandom;
            c.state_word = rv[15:0];
            rv = $urandom;
            c.round    = (rv[7:0] < 205) ? hot_round[rv[8]] : rv[13:9];
            c.fixation = (rv[23:16] < 205) ? hot_fix[rv[24]] : rv[28:25];
            len = $urandom_range(SI_W);
            rv  = $urandom;
            if (len == 0)
                c.sample_index = '0;
            else
                c.sample_index = (rv[SI_W-1:0] & ((12'd1 << (len - 1)) - 12'd1))
                                 | (12'd1 << (len - 1));
            sel = $urandom_range(99);
            if (sel < 10)
                c.size_exp = 4'(13 + sel % 3);
            else
                c.size_exp = 4'($urandom_range(NBINS - 1));
            pending_q.push_back(c);
            if (c.cmd != CMD_UNUSED)
                got++;
        end
    endfunction

    // Pile one output of every bin of a single plane up until the statistic clamps
    function automatic void queue_hot_lane();
        int rv;
        queue_cmd(CMD_CLEAR, 5'd0, 4'd0, 16'd0, 12'd0, 4'd0);
        for (int i = 1; i <= SAT_OBS; i++) begin
            rv = $urandom;
            queue_cmd(CMD_OBSERVE, 5'd5, 4'd9, rv[15:0] | 16'h0001, 12'd0, rv[31:28]);
            if (i % 16 == 0)
                queue_cmd(CMD_READ, 5'd5, 4'd9, rv[15:0], rv[27:16], 4'd0);
        end
        queue_cmd(CMD_READ, 5'd5, 4'd9, 16'd0, 12'd0, 4'd12);
        queue_cmd(CMD_READ, 5'd5, 4'd9, 16'd0, 12'd0, 4'd1);
        queue_cmd(CMD_READ, 5'd5, 4'd9, 16'd0, 12'd0, 4'd0);
        queue_cmd(CMD_READ, 5'd5, 4'd9, 16'd0, 12'd0, 4'd13);
    endfunction

    task automatic write_pos(input logic [1:0] idx, input logic [POS_W-1:0] pos);
        logic [APB_DW-POS_W-1:0] junk;
        junk = (APB_DW-POS_W)'($urandom);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, pos};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every transaction is taken and answered, then let clears finish
    task automatic wait_quiet();
        while (pending_q.size() != 0 || issued_count != accept_count
               || t_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : stim_proc
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty planes, field extremes, out-of-range reads, clear
        idle_pct = 17;
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd0);
        queue_cmd(CMD_READ,    5'd31, 4'd15, 16'hFFFF, 12'hFFF, 4'd12);
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd13);
        queue_cmd(CMD_READ,    5'd31, 4'd15, 16'hFFFF, 12'hFFF, 4'd15);
        queue_cmd(CMD_OBSERVE, 5'd0,  4'd0,  16'h0000, 12'h000, 4'd0);
        queue_cmd(CMD_OBSERVE, 5'd0,  4'd0,  16'hFFFF, 12'h000, 4'd15);
        queue_cmd(CMD_OBSERVE, 5'd31, 4'd15, 16'hFFFF, 12'hFFF, 4'd0);
        queue_cmd(CMD_OBSERVE, 5'd31, 4'd15, 16'h5A5A, 12'h001, 4'd7);
        queue_cmd(CMD_OBSERVE, 5'd0,  4'd0,  16'h000F, 12'h800, 4'd0);
        queue_cmd(CMD_UNUSED,  5'd31, 4'd15, 16'hFFFF, 12'hFFF, 4'd15);
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd0);
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd4);
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd12);
        queue_cmd(CMD_READ,    5'd31, 4'd15, 16'h0000, 12'h000, 4'd12);
        queue_cmd(CMD_READ,    5'd31, 4'd15, 16'h0000, 12'h000, 4'd1);
        queue_cmd(CMD_READ,    5'd31, 4'd15, 16'h0000, 12'h000, 4'd0);
        queue_cmd(CMD_CLEAR,   5'd17, 4'd6,  16'h1234, 12'h567, 4'd9);
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd0);
        queue_cmd(CMD_OBSERVE, 5'd0,  4'd0,  16'h8001, 12'h007, 4'd0);
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd3);
        queue_cmd(CMD_READ,    5'd0,  4'd0,  16'h0000, 12'h000, 4'd2);
        queue_mixed_traffic(200);
        wait_quiet();

        write_pos(REG_OUT_POS_0, 4'd15);
        write_pos(REG_OUT_POS_1, 4'd15);
        write_pos(REG_OUT_POS_2, 4'd15);
        write_pos(REG_OUT_POS_3, 4'd15);
        n_settings++;
        idle_pct = 58;
        queue_mixed_traffic(200);
        wait_quiet();

        write_pos(REG_OUT_POS_0, 4'($urandom));
        write_pos(REG_OUT_POS_1, 4'($urandom));
        write_pos(REG_OUT_POS_2, 4'($urandom));
        write_pos(REG_OUT_POS_3, 4'($urandom));
        n_settings++;
        idle_pct = 0;
        queue_mixed_traffic(200);
        wait_quiet();

        write_pos(REG_OUT_POS_0, 4'd0);
        write_pos(REG_OUT_POS_1, 4'd0);
        write_pos(REG_OUT_POS_2, 4'd0);
        write_pos(REG_OUT_POS_3, 4'd0);
        n_settings++;
        queue_hot_lane();
        wait_quiet();

        if (t_expect_q.size() != 0) begin
            mismatches += t_expect_q.size();
            $display("%0d reads never answered", t_expect_q.size());
        end
        $display("Covered %0d observe, %0d read and %0d clear transactions under %0d",
                 n_observe, n_read, n_clear, n_settings);
        $display("bit-position settings; %0d reads hit the statistic ceiling, %0d mismatches",
                 n_read_sat, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
